// ===== rtl/idh_pkg.sv =====
// ----------------------------------------------------------------------------
// idh_pkg
// Shared types and codes for the interpoint distance histogram.
// ----------------------------------------------------------------------------
package idh_pkg;

    typedef enum logic [2:0] {
        F_WR_COORD = 3'd0,
        F_WR_EDGE  = 3'd1,
        F_RUN      = 3'd2,
        F_RD_BIN   = 3'd3,
        F_CLEAR    = 3'd4
    } t_func;

    localparam logic [1:0] CFG_DIMS    = 2'd0;
    localparam logic [1:0] CFG_POINTS  = 2'd1;
    localparam logic [1:0] CFG_BINS    = 2'd2;
    localparam logic [1:0] CFG_THEILER = 2'd3;

    localparam int CFG_DATA_W = 11;
    localparam int EDGE_W     = 40;
    localparam int COUNT_W    = 32;
    localparam int PAIRS_W    = 11;

    typedef struct packed {
        logic [2:0]         func;
        logic [9:0]         point_index;
        logic [3:0]         coord_index;
        logic signed [15:0] coord_value;
        logic [4:0]         bin_index;
        logic [39:0]        edge_value;
    } t_in_word;

    typedef struct packed {
        logic [31:0] bin_count;
        logic [10:0] pairs_binned;
        logic        bad_index;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_REFLD,
        S_WALK,
        S_DRAIN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic ref_load;
        logic issue;
    } t_dp_cmd;

    typedef struct packed {
        logic run_ok;
        logic last_issue;
        logic pipe_busy;
    } t_dp_stat;

endpackage

// ===== rtl/idh_ctrl.sv =====
// ----------------------------------------------------------------------------
// idh_ctrl
// Sequencer: decode, reference load, point walk, drain and response.
// ----------------------------------------------------------------------------
module idh_ctrl
    import idh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_done
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.run_ok ? S_REFLD : S_RESP;
            end
            S_REFLD: n_state = S_WALK;
            S_WALK: begin
                if (i_stat.last_issue) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) n_state = S_RESP;
            end
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_start;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.ref_load = (r_state == S_REFLD);
        o_cmd.issue    = (r_state == S_WALK);
        o_busy         = (r_state != S_IDLE);
        o_done         = (r_state == S_RESP);
    end

endmodule

// ===== rtl/idh_datapath.sv =====
// ----------------------------------------------------------------------------
// idh_datapath
// Config registers, point store lanes, distance pipeline, edge search and
// histogram.
// ----------------------------------------------------------------------------
module idh_datapath
    import idh_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_DIMS   = 16,
    parameter int MAX_BINS   = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_word              i_word,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output t_out_word             o_result
);

    localparam int PA   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int LVL  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 0;
    localparam int P    = 1 << LVL;
    localparam int DW   = 2 * COORD_BITS + LVL;
    localparam int CW   = (DW > EDGE_W) ? DW : EDGE_W;
    localparam int BW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int NSTG = 3 + LVL;

    // config
    logic [4:0]  r_dims;
    logic [10:0] r_pts;
    logic [5:0]  r_bins;
    logic [9:0]  r_theiler;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims    <= 5'd2;
            r_pts     <= 11'd1024;
            r_bins    <= 6'd32;
            r_theiler <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DIMS:    r_dims    <= i_cfg_data[4:0];
                CFG_POINTS:  r_pts     <= i_cfg_data[10:0];
                CFG_BINS:    r_bins    <= i_cfg_data[5:0];
                CFG_THEILER: r_theiler <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    logic [6:0]  dims;
    logic [10:0] npts;
    logic [5:0]  nbins;

    assign dims  = (int'(r_dims) > MAX_DIMS) ? 7'(MAX_DIMS) : {2'b00, r_dims};
    assign npts  = (int'(r_pts) > MAX_POINTS) ? 11'(MAX_POINTS) : r_pts;
    assign nbins = (int'(r_bins) > MAX_BINS) ? 6'(MAX_BINS) : r_bins;

    // captured word and decode
    t_in_word r_item;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_item <= i_word;
    end

    logic bad_c;
    always_comb begin
        unique case (r_item.func)
            F_WR_COORD: bad_c = ({1'b0, r_item.point_index} >= npts) ||
                                ({3'b000, r_item.coord_index} >= dims);
            F_WR_EDGE:  bad_c = ({1'b0, r_item.bin_index} >= nbins);
            F_RUN:      bad_c = ({1'b0, r_item.point_index} >= npts);
            F_RD_BIN:   bad_c = ({1'b0, r_item.bin_index} >= nbins);
            default:    bad_c = 1'b0;
        endcase
    end

    logic [PA+9:0] pidx_ext;
    logic [PA-1:0] pidx_addr;
    logic [BW+4:0] bidx_ext;
    logic [BW-1:0] bidx;
    assign pidx_ext  = {{PA{1'b0}}, r_item.point_index};
    assign pidx_addr = pidx_ext[PA-1:0];
    assign bidx_ext  = {{BW{1'b0}}, r_item.bin_index};
    assign bidx      = bidx_ext[BW-1:0];

    logic do_wr_coord, do_wr_edge, do_rd_bin, do_clear;
    assign do_wr_coord = i_cmd.exec && (r_item.func == F_WR_COORD) && !bad_c;
    assign do_wr_edge  = i_cmd.exec && (r_item.func == F_WR_EDGE) && !bad_c;
    assign do_rd_bin   = i_cmd.exec && (r_item.func == F_RD_BIN) && !bad_c;
    assign do_clear    = i_cmd.exec && (r_item.func == F_CLEAR);

    // point walk
    logic [10:0]    r_j;
    logic [PA+10:0] j_ext;
    logic [PA-1:0]  j_addr;
    logic [PA-1:0]  rd_addr;
    logic [10:0]    gap;
    logic           issue_ok;

    assign j_ext   = {{PA{1'b0}}, r_j};
    assign j_addr  = j_ext[PA-1:0];
    assign rd_addr = i_cmd.exec ? pidx_addr : j_addr;
    assign gap     = (r_j > {1'b0, r_item.point_index}) ?
                     r_j - {1'b0, r_item.point_index} :
                     {1'b0, r_item.point_index} - r_j;
    assign issue_ok = i_cmd.issue && (gap > {1'b0, r_theiler});

    always_ff @(posedge i_clk) begin
        if (i_cmd.ref_load) begin
            r_j <= '0;
        end else if (i_cmd.issue) begin
            r_j <= r_j + 11'd1;
        end
    end

    logic signed [EDGE_W-1:0] cv_ext;
    assign cv_ext = EDGE_W'(r_item.coord_value);

    // lanes: store, reference, square
    logic [COORD_BITS-1:0] r_rd  [MAX_DIMS];
    logic [COORD_BITS-1:0] r_ref [MAX_DIMS];
    logic [DW-1:0]         r_node[2*P-1];

    for (genvar k = 0; k < MAX_DIMS; k++) begin : g_lane
        logic [COORD_BITS-1:0] mem [MAX_POINTS];
        logic signed [COORD_BITS:0]     diff;
        logic signed [2*COORD_BITS+1:0] prod;

        always_ff @(posedge i_clk) begin
            if (do_wr_coord && (int'(r_item.coord_index) == k)) begin
                mem[pidx_addr] <= cv_ext[COORD_BITS-1:0];
            end
            r_rd[k] <= mem[rd_addr];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.ref_load) r_ref[k] <= r_rd[k];
        end

        assign diff = signed'({r_ref[k][COORD_BITS-1], r_ref[k]}) -
                      signed'({r_rd[k][COORD_BITS-1], r_rd[k]});
        assign prod = diff * diff;

        always_ff @(posedge i_clk) begin
            r_node[P-1+k] <= (k < int'(dims)) ? DW'(prod[2*COORD_BITS-1:0]) : '0;
        end
    end

    for (genvar k = MAX_DIMS; k < P; k++) begin : g_pad
        always_ff @(posedge i_clk) begin
            r_node[P-1+k] <= '0;
        end
    end

    for (genvar n = 0; n < P - 1; n++) begin : g_tree
        always_ff @(posedge i_clk) begin
            r_node[n] <= r_node[2*n+1] + r_node[2*n+2];
        end
    end

    // valid line: read, square, tree levels, bin
    logic [NSTG-1:0] r_vpipe;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpipe <= '0;
        end else begin
            r_vpipe <= {r_vpipe[NSTG-2:0], issue_ok};
        end
    end

    // edge search
    logic [EDGE_W-1:0] r_edge[MAX_BINS];
    logic [CW-1:0]     dist_c;
    logic              hit_c;
    logic [BW-1:0]     bin_c;
    logic              r_hit;
    logic [BW-1:0]     r_bin;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_BINS; k++) begin
            if (do_wr_edge && (int'(r_item.bin_index) == k)) begin
                r_edge[k] <= r_item.edge_value;
            end
        end
    end

    assign dist_c = CW'(r_node[0]);

    always_comb begin
        hit_c = 1'b0;
        bin_c = '0;
        for (int k = MAX_BINS - 1; k >= 0; k--) begin
            if ((k < int'(nbins)) && (CW'(r_edge[k]) > dist_c)) begin
                hit_c = 1'b1;
                bin_c = BW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= r_vpipe[NSTG-2] && hit_c;
        end
        r_bin <= bin_c;
    end

    // histogram
    logic [COUNT_W-1:0]  r_hist[MAX_BINS];
    logic [MAX_BINS-1:0] r_hval;
    logic [BW-1:0]       h_addr;
    logic [COUNT_W-1:0]  h_val;
    logic [COUNT_W-1:0]  h_inc;

    assign h_addr = r_hit ? r_bin : bidx;
    assign h_val  = r_hval[h_addr] ? r_hist[h_addr] : '0;
    assign h_inc  = (h_val == '1) ? h_val : h_val + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hval <= '0;
        end else if (do_clear) begin
            r_hval <= '0;
        end else if (r_hit) begin
            r_hval[h_addr] <= 1'b1;
        end
        if (r_hit) r_hist[h_addr] <= h_inc;
    end

    // result
    logic                r_bad;
    logic [COUNT_W-1:0]  r_count;
    logic [PAIRS_W-1:0]  r_pairs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_bad   <= bad_c;
            r_count <= do_rd_bin ? h_val : '0;
            r_pairs <= '0;
        end else if (r_hit && (r_pairs != '1)) begin
            r_pairs <= r_pairs + 1'b1;
        end
    end

    assign o_result.bin_count    = r_count;
    assign o_result.pairs_binned = r_pairs;
    assign o_result.bad_index    = r_bad;

    assign o_stat.run_ok     = (r_item.func == F_RUN) && !bad_c;
    assign o_stat.last_issue = (r_j == npts - 11'd1);
    assign o_stat.pipe_busy  = (|r_vpipe) || r_hit;

endmodule

// ===== rtl/interpoint_distance_histogram.sv =====
// ----------------------------------------------------------------------------
// interpoint_distance_histogram
// Correlation-sum distance histogram with an index exclusion band.
// ----------------------------------------------------------------------------
// Usage: present a word on i_word with i_start high; it is taken at an edge
// where o_busy is low. Exactly one result word per input appears on o_result
// for one cycle with o_done high; the receiver cannot hold it off.
// Config writes (i_cfg_we, i_cfg_addr, i_cfg_data) land at the clock edge; the
// user must make them only while o_busy is low, as the block does not enforce it.
// Sequence: writes, reads, clears and rejected items are decoded and then
// give o_done. A run then loads the reference point, walks the N points in
// use and waits for the pipeline to drain before o_done: the point store
// is read one row per cycle, all dimensions in parallel lanes, followed by
// a square stage, a registered adder tree, the edge search and the
// histogram update.
// One item is in flight at a time; o_busy stays high until o_done.
// Reset: config registers return to defaults, the histogram reads zero; the
// point store and edge table hold garbage until written.
// ----------------------------------------------------------------------------
module interpoint_distance_histogram
    import idh_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_DIMS   = 16,
    parameter int MAX_BINS   = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_in_word              i_word,
    output logic                  o_done,
    output t_out_word             o_result,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    idh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    idh_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIMS   (MAX_DIMS),
        .MAX_BINS   (MAX_BINS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_word     (i_word),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_result   (o_result)
    );

endmodule

// ===== rtl/idh_checker.sv =====
// ----------------------------------------------------------------------------
// idh_checker
// Port-level checks on the command handshake and result word.
// ----------------------------------------------------------------------------
module idh_checker
    import idh_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_start,
    input logic      o_busy,
    input logic      o_done,
    input t_out_word o_result
);

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy)
        else $error("done without busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !o_busy))
        else $error("done not a single cycle ending the item");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_start && !o_busy) |=> o_busy)
        else $error("accepted word did not raise busy");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.bad_index) |->
            (o_result.bin_count == '0 && o_result.pairs_binned == '0))
        else $error("rejected item returned data");

endmodule

bind interpoint_distance_histogram idh_checker u_idh_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// ===== tb/interpoint_distance_histogram_tb.sv =====
// ----------------------------------------------------------------------------
// interpoint_distance_histogram_tb
// Self-checking bench for the interpoint distance histogram. A directed table
// runs first. Then several size settings follow, each with the points and
// edges loaded and a random mix of words. A bit-accurate distance and bin
// predictor produces each expected result word after the table, and a
// monitor checks every o_done strobe against the oldest expectation.
// ----------------------------------------------------------------------------
module interpoint_distance_histogram_tb;
    import idh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS_MAX  = 1024;
    localparam int NDIMS_MAX = 16;
    localparam int NBINS_MAX = 32;
    localparam int STALL_LIMIT = 20000;
    localparam int RAND_PER_PHASE = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_in_word              i_word;
    logic                  o_done;
    t_out_word             o_result;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    interpoint_distance_histogram i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_word     (i_word),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // predictor state
    logic signed [15:0] coord_mem [NPTS_MAX][NDIMS_MAX];
    bit                 coord_set [NPTS_MAX][NDIMS_MAX];
    logic [39:0]        edge_mem  [NBINS_MAX];
    logic [31:0]        bin_mem   [NBINS_MAX];
    int unsigned        dims_reg, points_reg, bins_reg, band_reg;

    t_out_word pending_results [$];
    bit        failed;
    int        idle_cycles;
    int        burst_left;
    bit        steady;

    function automatic int unsigned clip(int unsigned v, int unsigned hi);
        return (v > hi) ? hi : v;
    endfunction

    function automatic t_out_word histogram_step(t_in_word w);
        t_out_word   r;
        int unsigned nd, np, nb, gap;
        longint unsigned sq_d, ad;
        int d;
        nd = clip(dims_reg, NDIMS_MAX);
        np = clip(points_reg, NPTS_MAX);
        nb = clip(bins_reg, NBINS_MAX);
        r = '0;
        case (w.func)
            F_WR_COORD: begin
                if (w.point_index >= np || w.coord_index >= nd) begin
                    r.bad_index = 1'b1;
                end else begin
                    coord_mem[w.point_index][w.coord_index] = w.coord_value;
                    coord_set[w.point_index][w.coord_index] = 1'b1;
                end
            end
            F_WR_EDGE: begin
                if (w.bin_index >= nb) r.bad_index = 1'b1;
                else edge_mem[w.bin_index] = w.edge_value;
            end
            F_RUN: begin
                if (w.point_index >= np) begin
                    r.bad_index = 1'b1;
                end else begin
                    for (int j = 0; j < np; j++) begin
                        gap = (j > w.point_index) ? j - w.point_index : w.point_index - j;
                        if (gap <= band_reg) continue;
                        sq_d = 0;
                        for (int k = 0; k < nd; k++) begin
                            d = int'(coord_mem[w.point_index][k]) - int'(coord_mem[j][k]);
                            ad = (d < 0) ? longint'(-d) : longint'(d);
                            sq_d += ad * ad;
                        end
                        for (int k = 0; k < nb; k++) begin
                            if (longint'(edge_mem[k]) > sq_d) begin
                                if (bin_mem[k] != 32'hFFFF_FFFF) bin_mem[k]++;
                                if (r.pairs_binned != 11'h7FF) r.pairs_binned++;
                                break;
                            end
                        end
                    end
                end
            end
            F_RD_BIN: begin
                if (w.bin_index >= nb) r.bad_index = 1'b1;
                else r.bin_count = bin_mem[w.bin_index];
            end
            F_CLEAR: begin
                for (int k = 0; k < NBINS_MAX; k++) bin_mem[k] = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_in_word mk(logic [2:0] f, int p, int c, int v, int b,
                                    longint e);
        t_in_word w;
        w.func        = f;
        w.point_index = p[9:0];
        w.coord_index = c[3:0];
        w.coord_value = v[15:0];
        w.bin_index   = b[4:0];
        w.edge_value  = e[39:0];
        return w;
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        w.func        = 3'($urandom);
        w.point_index = 10'($urandom);
        w.coord_index = 4'($urandom);
        w.coord_value = 16'($urandom);
        w.bin_index   = 5'($urandom);
        w.edge_value  = {8'($urandom), 32'($urandom)};
        return w;
    endfunction

    // Called just after a rising edge; returns after acceptance or a pause.
    task automatic issue(t_in_word w, bit typed, t_out_word typed_res);
        t_out_word p;
        i_start <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_busy);
        p = histogram_step(w);
        pending_results.push_back(typed ? typed_res : p);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 20);
            if (!steady && $urandom_range(0, 2) != 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    task automatic send(t_in_word w);
        issue(w, 1'b0, '0);
    endtask

    task automatic set_sizes(int unsigned nd, int unsigned np, int unsigned nb,
                             int unsigned tb);
        int unsigned vals [4];
        i_start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge i_clk);
        vals = '{nd, np, nb, tb};
        for (int a = 0; a < 4; a++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= a[1:0];
            i_cfg_data <= vals[a][CFG_DATA_W-1:0];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        dims_reg   = nd & 32'h1F;
        points_reg = np & 32'h7FF;
        bins_reg   = nb & 32'h3F;
        band_reg   = tb & 32'h3FF;
    endtask

    function automatic int rand_coord();
        if ($urandom_range(0, 1)) return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 200)) - 100;
    endfunction

    task automatic load_phase();
        int unsigned nd, np, nb;
        longint unsigned step, acc;
        nd = clip(dims_reg, NDIMS_MAX);
        np = clip(points_reg, NPTS_MAX);
        nb = clip(bins_reg, NBINS_MAX);
        for (int p = 0; p < np; p++)
            for (int c = 0; c < nd; c++)
                if (!coord_set[p][c]) send(mk(F_WR_COORD, p, c, rand_coord(), 0, 0));
        if (nb == 0) return;
        if ($urandom_range(0, 1))
            step = longint'($urandom_range(1, 3000));
        else
            step = (longint'(nd > 0 ? nd : 1) << 33) / nb + 1;
        acc = 0;
        for (int b = 0; b < nb; b++) begin
            acc += step;
            send(mk(F_WR_EDGE, 0, 0, 0, b, acc));
        end
    endtask

    task automatic random_mix(int n);
        t_in_word w;
        int unsigned r, np, nd;
        np = clip(points_reg, NPTS_MAX);
        nd = clip(dims_reg, NDIMS_MAX);
        for (int i = 0; i < n; i++) begin
            w = rand_word();
            r = $urandom_range(0, 99);
            if (r < 15) begin
                w.func = F_WR_COORD;
                if (np > 0 && nd > 0 && $urandom_range(0, 4) != 0) begin
                    w.point_index = 10'($urandom_range(0, np - 1));
                    w.coord_index = 4'($urandom_range(0, nd - 1));
                end
            end else if (r < 25) begin
                w.func = F_WR_EDGE;
            end else if (r < 55) begin
                w.func = F_RUN;
                if (np > 0 && $urandom_range(0, 9) != 0)
                    w.point_index = 10'($urandom_range(0, np - 1));
            end else if (r < 85) begin
                w.func = F_RD_BIN;
            end else if (r < 92) begin
                w.func = F_CLEAR;
            end else begin
                w.func = 3'($urandom_range(5, 7));
            end
            send(w);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word %h", $realtime, o_result);
                failed = 1'b1;
            end else begin
                e = pending_results.pop_front();
                if (o_result.bin_count !== e.bin_count) begin
                    $display("%0t: bin_count expected %h actual %h",
                             $realtime, e.bin_count, o_result.bin_count);
                    failed = 1'b1;
                end
                if (o_result.pairs_binned !== e.pairs_binned) begin
                    $display("%0t: pairs_binned expected %0d actual %0d",
                             $realtime, e.pairs_binned, o_result.pairs_binned);
                    failed = 1'b1;
                end
                if (o_result.bad_index !== e.bad_index) begin
                    $display("%0t: bad_index expected %b actual %b",
                             $realtime, e.bad_index, o_result.bad_index);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    typedef struct {
        t_in_word  w;
        t_out_word r;
    } t_row;

    initial begin
        t_row rows [$];
        t_out_word ok, bad;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_word      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_data  = '0;
        failed      = 1'b0;
        idle_cycles = 0;
        burst_left  = 0;
        steady      = 1'b0;
        dims_reg    = 2;
        points_reg  = 1024;
        bins_reg    = 32;
        band_reg    = 0;
        for (int k = 0; k < NBINS_MAX; k++) begin
            bin_mem[k]  = '0;
            edge_mem[k] = '0;
        end
        for (int p = 0; p < NPTS_MAX; p++)
            for (int c = 0; c < NDIMS_MAX; c++) begin
                coord_mem[p][c] = '0;
                coord_set[p][c] = 1'b0;
            end
        ok  = '0;
        bad = '0;
        bad.bad_index = 1'b1;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back('{mk(F_RD_BIN, 0, 0, 0, 0, 0), ok});
        rows.push_back('{mk(F_RD_BIN, 0, 0, 0, 31, 0), ok});
        rows.push_back('{mk(F_WR_COORD, 0, 2, 5, 0, 0), bad});
        rows.push_back('{mk(F_WR_COORD, 1023, 15, -1, 31, -1), bad});
        rows.push_back('{mk(F_WR_COORD, 1023, 1, -32768, 0, 0), ok});
        rows.push_back('{mk(F_WR_COORD, 0, 0, 32767, 0, 0), ok});
        rows.push_back('{mk(F_WR_COORD, 1023, 0, 0, 0, 0), ok});
        rows.push_back('{mk(F_WR_EDGE, 1023, 15, -1, 31, 64'hFF_FFFF_FFFF), ok});
        rows.push_back('{mk(F_WR_EDGE, 0, 0, 0, 0, 0), ok});
        rows.push_back('{mk(F_RD_BIN, 0, 0, 0, 15, 0), ok});
        rows.push_back('{mk(F_CLEAR, 0, 0, 0, 0, 0), ok});
        rows.push_back('{mk(3'd5, 1023, 15, -1, 31, -1), ok});
        rows.push_back('{mk(3'd6, 0, 0, 0, 0, 0), ok});
        rows.push_back('{mk(3'd7, 1023, 15, -1, 31, -1), ok});
        rows.push_back('{mk(F_RD_BIN, 1023, 15, -1, 31, -1), ok});
        foreach (rows[i]) issue(rows[i].w, 1'b1, rows[i].r);

        set_sizes(2, 6, 4, 0);      load_phase(); random_mix(RAND_PER_PHASE);
        set_sizes(1, 10, 8, 1);     load_phase(); random_mix(RAND_PER_PHASE);
        steady = 1'b1;
        set_sizes(31, 2, 63, 0);    load_phase(); random_mix(RAND_PER_PHASE);
        steady = 1'b0;
        set_sizes(3, 8, 0, 2);      load_phase(); random_mix(RAND_PER_PHASE);
        set_sizes(2, 0, 5, 0);      load_phase(); random_mix(RAND_PER_PHASE / 2);
        set_sizes(0, 2047, 6, 1023); load_phase(); random_mix(RAND_PER_PHASE / 2);
        set_sizes(0, 1024, 32, 0);  load_phase(); random_mix(RAND_PER_PHASE / 2);
        set_sizes(4, 12, 6, 3);     load_phase(); random_mix(RAND_PER_PHASE);
        set_sizes(2, 5, 1, 0);      load_phase(); random_mix(RAND_PER_PHASE);
        set_sizes(16, 3, 32, 1);    load_phase(); random_mix(RAND_PER_PHASE);

        i_start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (64) @(posedge i_clk);
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
